@@ hdl/lsdp_pkg.sv @@
`timescale 1ns / 1ps

package lsdp_pkg;

    // Field widths fixed by the interface
    localparam int ADDR_W   = 48;
    localparam int BIN_W    = 8;
    localparam int DIST_W   = 8;
    localparam int COUNT_W  = 32;
    localparam int TOTAL_W  = 48;
    localparam int CFG_W    = 9;
    localparam int BLK_W    = 3;
    localparam int HIST_BINS = 256;

    localparam logic [COUNT_W-1:0] BIN_MAX   = '1;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;
    localparam logic [DIST_W-1:0]  DIST_MAX  = '1;

    // Configuration register indexes
    localparam logic REG_STACK_LIMIT = 1'b0;
    localparam logic REG_BLOCK_LOG2  = 1'b1;

    // Operation codes
    localparam logic OP_ACCESS = 1'b0;
    localparam logic OP_READ   = 1'b1;

    localparam logic [CFG_W-1:0] LIMIT_RESET = 9'd256;
    localparam logic [BLK_W-1:0] BLOCK_RESET = 3'd6;

    typedef struct packed {
        logic              op;
        logic [ADDR_W-1:0] address;
        logic [BIN_W-1:0]  bin_index;
    } t_in;

    typedef struct packed {
        logic               hit;
        logic [DIST_W-1:0]  distance;
        logic [COUNT_W-1:0] bin_count;
        logic [TOTAL_W-1:0] total_count;
    } t_out;

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic scan_start;
        logic scan;
        logic scan_wr;
        logic set_hit;
        logic hist_rd;
        logic hist_inc;
        logic mod_step;
        logic sub_init;
        logic sub_next;
        logic fin;
        logic load_out;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic in_op;
        logic op;
        logic scan_end;
        logic match;
        logic mod_done;
        logic last_sub;
    } t_sts;

endpackage

@@ hdl/lru_stack_distance_profiler.sv @@
`timescale 1ns / 1ps
// LRU stack distance profiler.
// Input channel (i_in_valid / o_in_ready, payload i_in): one beat per operation.
//   op 0 is a memory access: looked up in the LRU stack, moved to the top on a
//   hit (distance counted in the histogram), whole line inserted on a miss.
//   op 1 reads one histogram bin together with the access total.
// Output channel (o_out_valid / i_out_ready, payload o_out): one beat per input.
// Configuration: i_cfg_we writes i_cfg_data to register i_cfg_idx
//   (0 = stack limit, 1 = block size log2); write only while the block is idle.
// One operation at a time, its duration set by the single-port stack memory scan:
//   read: one histogram read; hit at depth d: a lookup pass to depth d, a
//   histogram update and a move pass to the top; miss: a full lookup pass, one
//   step per address byte for the line remainder when LINE_BYTES is not a power
//   of two, then one insertion pass per block of the line.
// A new beat is taken once the previous result sits in the output register,
// even if the receiver has not yet taken it; a stalled result holds.
// Reset (synchronous, active low) empties the stack, clears the histogram and
// the total, and loads the configuration defaults; no clearing pass is needed.
module lru_stack_distance_profiler #(
    parameter int STACK_DEPTH = 256,
    parameter int LINE_BYTES  = 64,
    parameter int ADDR_BITS   = 48
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  lsdp_pkg::t_in              i_in,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output lsdp_pkg::t_out             o_out,
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_idx,
    input  logic [lsdp_pkg::CFG_W-1:0] i_cfg_data
);
    import lsdp_pkg::*;

    t_cmd cmd;
    t_sts sts;

    lsdp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    lsdp_dp #(
        .STACK_DEPTH (STACK_DEPTH),
        .LINE_BYTES  (LINE_BYTES),
        .ADDR_BITS   (ADDR_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_out      (o_out)
    );

endmodule

@@ hdl/lsdp_dp.sv @@
`timescale 1ns / 1ps

module lsdp_dp #(
    parameter int STACK_DEPTH = 256,
    parameter int LINE_BYTES  = 64,
    parameter int ADDR_BITS   = 48
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  lsdp_pkg::t_in               i_in,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_idx,
    input  logic [lsdp_pkg::CFG_W-1:0]  i_cfg_data,
    input  lsdp_pkg::t_cmd              i_cmd,
    output lsdp_pkg::t_sts              o_sts,
    output lsdp_pkg::t_out              o_out
);
    import lsdp_pkg::*;

    localparam int OW  = $clog2(STACK_DEPTH + 1);
    localparam int AIW = $clog2(STACK_DEPTH);
    localparam int LW  = (OW > CFG_W) ? OW : CFG_W;
    localparam int LG  = $clog2(LINE_BYTES + 1) - 1;
    localparam bit LINE_POW2 = ((LINE_BYTES & (LINE_BYTES - 1)) == 0);
    // Line remainder: one address byte per step, quotient by reciprocal multiply
    localparam int NBY   = (ADDR_BITS + 7) / 8;
    localparam int PW    = NBY * 8;
    localparam int MCW   = $clog2(NBY + 1);
    localparam int RS    = 25;
    localparam int RECIP = ((1 << RS) + LINE_BYTES - 1) / LINE_BYTES;

    // Configuration
    logic [CFG_W-1:0] r_lim_cfg;
    logic [BLK_W-1:0] r_blk_cfg;

    // Captured item
    logic                 r_op;
    logic [ADDR_BITS-1:0] r_addr;

    // Stack scan
    logic [ADDR_BITS-1:0] stack_mem [STACK_DEPTH];
    logic [ADDR_BITS-1:0] r_key;
    logic [ADDR_BITS-1:0] r_hold;
    logic [ADDR_BITS-1:0] r_rd;
    logic [OW-1:0]        r_idx;
    logic [OW-1:0]        r_pidx;
    logic                 r_rdv;
    logic [OW-1:0]        r_occ;

    // Line remainder and sub-blocks
    logic [8:0]           r_rem;
    logic [PW-1:0]        r_msh;
    logic [MCW-1:0]       r_mcnt;
    logic [8:0]           r_k;

    // Histogram
    logic [COUNT_W-1:0]   hist_mem [HIST_BINS];
    logic [HIST_BINS-1:0] r_hv;
    logic [BIN_W-1:0]     r_hidx;
    logic [COUNT_W-1:0]   r_hrd;
    logic                 r_hok;

    logic                 r_hit;
    logic [DIST_W-1:0]    r_dist;
    logic [TOTAL_W-1:0]   r_total;
    t_out                 r_out;

    logic [BLK_W-1:0]     blk_eff;
    logic [ADDR_BITS-1:0] bsize;
    logic [ADDR_BITS-1:0] addr_in;
    logic [ADDR_BITS-1:0] base;
    logic [LW-1:0]        lim_ext;
    logic [LW-1:0]        occ_ext;
    logic [8:0]           nblk;
    logic [8:0]           span;
    logic [15:0]          mod_x;
    logic [41:0]          mod_prod;
    logic [15:0]          mod_qm;
    logic [15:0]          rem_nx;
    logic                 match;
    logic                 rd_issue;
    logic                 mem_we;
    logic [AIW-1:0]       mem_wa;
    logic [ADDR_BITS-1:0] mem_wd;
    logic [DIST_W-1:0]    dsat;
    logic [COUNT_W-1:0]   hval;

    // Effective block size and stack limit
    assign blk_eff = ({1'b0, r_blk_cfg} > 4'(LG)) ? BLK_W'(LG) : r_blk_cfg;
    assign bsize   = ADDR_BITS'(1) << blk_eff;
    assign lim_ext = (r_lim_cfg == '0) ? LW'(1) :
                     ((LW'(r_lim_cfg) > LW'(STACK_DEPTH)) ? LW'(STACK_DEPTH) : LW'(r_lim_cfg));
    assign occ_ext = LW'(r_occ);
    assign addr_in = ADDR_BITS'(i_in.address);

    // Line base and first sub-block offset
    assign base = LINE_POW2 ? (r_addr & ~ADDR_BITS'(LINE_BYTES - 1))
                            : (r_addr - ADDR_BITS'(r_rem));
    assign nblk = 9'(LINE_BYTES) >> blk_eff;
    assign span = 9'(nblk << blk_eff) - (9'(1) << blk_eff);

    // One address byte per step, most significant first
    assign mod_x    = {r_rem[7:0], r_msh[PW-1 -: 8]};
    assign mod_prod = 42'(mod_x) * 42'(RECIP);
    assign mod_qm   = {8'b0, mod_prod[RS +: 8]} * 16'(LINE_BYTES);
    assign rem_nx   = mod_x - mod_qm;

    // Scan compare
    assign match    = r_rdv && (r_rd == r_key);
    assign rd_issue = i_cmd.scan && (r_idx < r_occ);
    assign dsat     = (32'(r_pidx) > 32'(DIST_MAX)) ? DIST_MAX : DIST_W'(r_pidx);
    assign hval     = r_hok ? r_hrd : '0;

    assign o_sts.in_op    = i_in.op;
    assign o_sts.op       = r_op;
    assign o_sts.match    = match;
    assign o_sts.scan_end = match || (r_rdv && (OW'(r_pidx + OW'(1)) == r_occ))
                            || (r_occ == '0);
    assign o_sts.mod_done = LINE_POW2 || (r_mcnt == MCW'(NBY));
    assign o_sts.last_sub = (r_k == '0);
    assign o_out          = r_out;

    // Stack write port: shift during a pass, tail write after an insertion
    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_pidx[AIW-1:0];
        mem_wd = r_hold;
        if (i_cmd.scan && i_cmd.scan_wr && r_rdv) begin
            mem_we = 1'b1;
        end else if (i_cmd.fin && (occ_ext < lim_ext)) begin
            mem_we = 1'b1;
            mem_wa = r_occ[AIW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            stack_mem[mem_wa] <= mem_wd;
        end
        r_rd <= stack_mem[r_idx[AIW-1:0]];
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lim_cfg <= LIMIT_RESET;
            r_blk_cfg <= BLOCK_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_STACK_LIMIT: r_lim_cfg <= i_cfg_data;
                REG_BLOCK_LOG2:  r_blk_cfg <= i_cfg_data[BLK_W-1:0];
                default: ;
            endcase
        end
    end

    // Occupancy, total and histogram valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ   <= '0;
            r_total <= '0;
            r_hv    <= '0;
            r_rdv   <= 1'b0;
        end else begin
            if (i_cmd.capture && (i_in.op == OP_ACCESS) && (r_total != TOTAL_MAX)) begin
                r_total <= r_total + TOTAL_W'(1);
            end
            if (i_cmd.fin) begin
                r_occ <= (occ_ext < lim_ext) ? OW'(r_occ + OW'(1)) : OW'(lim_ext);
            end
            if (i_cmd.hist_inc) begin
                r_hv[r_hidx] <= 1'b1;
            end
            if (i_cmd.scan_start) begin
                r_rdv <= 1'b0;
            end else if (i_cmd.scan) begin
                r_rdv <= rd_issue;
            end
        end
    end

    // Item capture, scan and sub-block registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op   <= i_in.op;
            r_addr <= addr_in;
            r_key  <= addr_in & ~(bsize - ADDR_BITS'(1));
            r_hidx <= i_in.bin_index;
            r_hit  <= 1'b0;
            r_dist <= '0;
            r_rem  <= '0;
            r_msh  <= PW'(addr_in);
            r_mcnt <= '0;
        end
        if (i_cmd.scan_start) begin
            r_idx  <= '0;
            r_hold <= r_key;
        end else if (i_cmd.scan) begin
            if (rd_issue) begin
                r_idx  <= OW'(r_idx + OW'(1));
                r_pidx <= r_idx;
            end
            if (r_rdv) begin
                r_hold <= r_rd;
            end
        end
        if (i_cmd.set_hit) begin
            r_hit  <= 1'b1;
            r_dist <= dsat;
            r_hidx <= dsat;
        end
        if (i_cmd.mod_step) begin
            r_rem  <= 9'(rem_nx);
            r_msh  <= r_msh << 8;
            r_mcnt <= MCW'(r_mcnt + MCW'(1));
        end
        if (i_cmd.sub_init) begin
            r_key <= base + ADDR_BITS'(span);
            r_k   <= nblk - 9'(1);
        end else if (i_cmd.sub_next) begin
            r_key <= r_key - bsize;
            r_k   <= r_k - 9'(1);
        end
    end

    // Histogram memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.hist_inc) begin
            hist_mem[r_hidx] <= (hval == BIN_MAX) ? hval : hval + COUNT_W'(1);
        end
        if (i_cmd.hist_rd) begin
            r_hrd <= hist_mem[r_hidx];
            r_hok <= r_hv[r_hidx];
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out.hit         <= r_hit;
            r_out.distance    <= r_dist;
            r_out.bin_count   <= (r_op == OP_READ) ? hval : '0;
            r_out.total_count <= r_total;
        end
    end

endmodule

@@ hdl/lsdp_ctrl.sv @@
`timescale 1ns / 1ps

module lsdp_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    input  lsdp_pkg::t_sts i_sts,
    output lsdp_pkg::t_cmd o_cmd
);
    import lsdp_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_HREAD  = 4'd1;
    localparam logic [3:0] S_HINC   = 4'd2;
    localparam logic [3:0] S_LSTART = 4'd3;
    localparam logic [3:0] S_LOOK   = 4'd4;
    localparam logic [3:0] S_MOD    = 4'd5;
    localparam logic [3:0] S_ISTART = 4'd6;
    localparam logic [3:0] S_INS    = 4'd7;
    localparam logic [3:0] S_FIN    = 4'd8;
    localparam logic [3:0] S_NEXT   = 4'd9;
    localparam logic [3:0] S_MSTART = 4'd10;
    localparam logic [3:0] S_MOVE   = 4'd11;
    localparam logic [3:0] S_DONE   = 4'd12;

    logic [3:0] r_state, n_state;
    logic       r_ov, n_ov;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ov;

    // Sequencing of lookup, histogram update and stack passes
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        n_ov    = r_ov && !i_out_ready;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state = (i_sts.in_op == OP_READ) ? S_HREAD : S_LSTART;
                end
            end
            S_HREAD: begin
                o_cmd.hist_rd = 1'b1;
                n_state = (i_sts.op == OP_READ) ? S_DONE : S_HINC;
            end
            S_HINC: begin
                o_cmd.hist_inc = 1'b1;
                n_state = S_MSTART;
            end
            S_LSTART: begin
                o_cmd.scan_start = 1'b1;
                n_state = S_LOOK;
            end
            S_LOOK: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_end) begin
                    if (i_sts.match) begin
                        o_cmd.set_hit = 1'b1;
                        n_state = S_HREAD;
                    end else begin
                        n_state = S_MOD;
                    end
                end
            end
            S_MOD: begin
                if (i_sts.mod_done) begin
                    o_cmd.sub_init = 1'b1;
                    n_state = S_ISTART;
                end else begin
                    o_cmd.mod_step = 1'b1;
                end
            end
            S_ISTART: begin
                o_cmd.scan_start = 1'b1;
                n_state = S_INS;
            end
            S_INS: begin
                o_cmd.scan    = 1'b1;
                o_cmd.scan_wr = 1'b1;
                if (i_sts.scan_end) begin
                    n_state = i_sts.match ? S_NEXT : S_FIN;
                end
            end
            S_FIN: begin
                o_cmd.fin = 1'b1;
                n_state = S_NEXT;
            end
            S_NEXT: begin
                if (i_sts.last_sub) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.sub_next = 1'b1;
                    n_state = S_ISTART;
                end
            end
            S_MSTART: begin
                o_cmd.scan_start = 1'b1;
                n_state = S_MOVE;
            end
            S_MOVE: begin
                o_cmd.scan    = 1'b1;
                o_cmd.scan_wr = 1'b1;
                if (i_sts.scan_end) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_ov || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_ov    = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
        end
    end

endmodule

@@ hdl/lsdp_chk.sv @@
`timescale 1ns / 1ps

module lsdp_chk (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       o_in_ready,
    input lsdp_pkg::t_in              i_in,
    input logic                       o_out_valid,
    input logic                       i_out_ready,
    input lsdp_pkg::t_out             o_out
);
    import lsdp_pkg::*;

    // Waiting input beat holds
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_ready |=> i_in_valid && $stable(i_in))
        else $error("input beat changed while waiting");

    // Stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("result beat changed while stalled");

    // Misses and reads report distance zero
    a_miss_dist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out.hit |-> o_out.distance == '0)
        else $error("distance without a hit");

    // A hit is an access, so it carries no bin count
    a_hit_bin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.hit |-> o_out.bin_count == '0)
        else $error("bin count on an access result");

    // Reset drops any pending result
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind lru_stack_distance_profiler lsdp_chk u_chk (.*);
